@@ rtl/ssse_pkg.sv @@
package ssse_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int IDX_W      = 6;
  localparam int KEY_W      = 64;
  localparam int CAL_W      = 32;
  localparam int CHOSEN_W   = 3;

  typedef enum logic [1:0] {
    FUNC_ATTACH = 2'd0,
    FUNC_SELECT = 2'd1,
    FUNC_COMMIT = 2'd2
  } ssse_func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ATTACH,
    S_COMMIT,
    S_MATCH,
    S_EVICT,
    S_RESULT
  } ssse_state_e;

  typedef struct packed {
    logic load;
    logic attach;
    logic commit;
    logic match;
    logic evict;
  } ssse_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cvalid;
    logic       match_end;
    logic       go_evict;
    logic       evict_end;
  } ssse_stat_t;

  function automatic logic [CHOSEN_W-1:0] slot_to_out(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W+CHOSEN_W-1:0] wide;
    wide = {{CHOSEN_W{1'b0}}, slot};
    return wide[CHOSEN_W-1:0];
  endfunction

endpackage

@@ rtl/ssse_ctrl.sv @@
module ssse_ctrl
  import ssse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  ssse_stat_t stat_i,
  output ssse_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  ssse_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.func)
          FUNC_ATTACH: state_d = S_ATTACH;
          FUNC_SELECT: state_d = stat_i.cvalid ? S_MATCH : S_RESULT;
          FUNC_COMMIT: state_d = S_COMMIT;
          default:     state_d = S_RESULT;
        endcase
      end
      S_ATTACH: state_d = S_RESULT;
      S_COMMIT: state_d = S_RESULT;
      S_MATCH: begin
        if (stat_i.match_end) state_d = stat_i.go_evict ? S_EVICT : S_RESULT;
      end
      S_EVICT: begin
        if (stat_i.evict_end) state_d = S_RESULT;
      end
      S_RESULT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.attach = (state_q == S_ATTACH);
    cmd_o.commit = (state_q == S_COMMIT);
    cmd_o.match  = (state_q == S_MATCH);
    cmd_o.evict  = (state_q == S_EVICT);
    busy_o       = (state_q != S_IDLE);
    done_o       = (state_q == S_RESULT);
  end

endmodule

@@ rtl/ssse_dp.sv @@
module ssse_dp
  import ssse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssse_cmd_t           cmd_i,
  input  logic [1:0]          func_i,
  input  logic                candidate_valid_i,
  input  logic [KEY_W-1:0]    sensor_key_i,
  input  logic [KEY_W-1:0]    firmware_key_i,
  input  logic [CAL_W-1:0]    cal_version_i,
  input  logic [IDX_W-1:0]    slot_index_i,
  output ssse_stat_t          stat_o,
  output logic [CHOSEN_W-1:0] chosen_slot_o,
  output logic                unchanged_o,
  output logic                status_o
);

  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W:0]   SlotNum  = (SLOT_W + 1)'(SLOT_COUNT);
  localparam logic [IDX_W:0]    IdxLimit = (IDX_W + 1)'(SLOT_COUNT);

  logic [1:0]       func_q;
  logic             cvalid_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] fw_q;
  logic [CAL_W-1:0] cal_q;
  logic [IDX_W-1:0] idx_q;

  logic [SLOT_COUNT-1:0] rec_valid_q;
  logic [KEY_W-1:0]      rec_sensor_q [SLOT_COUNT];
  logic [KEY_W-1:0]      rec_fw_q     [SLOT_COUNT];
  logic [CAL_W-1:0]      rec_cal_q    [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] att_present_q;
  logic [KEY_W-1:0]      att_sensor_q [SLOT_COUNT];
  logic [SLOT_W-1:0]     ptr_q, ptr_d;

  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              empty_vld_q, empty_vld_d;
  logic [SLOT_W-1:0] empty_q, empty_d;
  logic [SLOT_W-1:0] chosen_q, chosen_d;
  logic              same_q, same_d;
  logic              status_q, status_d;

  logic              idx_ok;
  logic [SLOT_W-1:0] idx_slot;
  logic [SLOT_W:0]   evict_sum;
  logic [SLOT_W-1:0] evict_slot;
  logic [SLOT_W-1:0] rd_addr;
  logic              rd_valid;
  logic [KEY_W-1:0]  rd_sensor;
  logic              hit;
  logic              last;
  logic [SLOT_COUNT-1:0] att_match;
  logic              attached;
  logic              commit_ok;

  assign idx_ok   = {1'b0, idx_q} < IdxLimit;
  assign idx_slot = idx_q[SLOT_W-1:0];
  assign last     = (cnt_q == LastSlot);

  always_comb begin
    evict_sum = {1'b0, ptr_q} + {1'b0, cnt_q};
    if (evict_sum >= SlotNum) evict_sum = evict_sum - SlotNum;
    evict_slot = evict_sum[SLOT_W-1:0];
  end

  always_comb begin
    rd_addr = cnt_q;
    if (cmd_i.evict)  rd_addr = evict_slot;
    if (cmd_i.commit) rd_addr = idx_slot;
  end

  assign rd_valid  = rec_valid_q[rd_addr];
  assign rd_sensor = rec_sensor_q[rd_addr];
  assign hit       = rd_valid && (rd_sensor == key_q);
  assign commit_ok = cvalid_q && idx_ok;

  always_comb begin
    for (int k = 0; k < SLOT_COUNT; k++) begin
      att_match[k] = att_present_q[k] && (att_sensor_q[k] == rd_sensor);
    end
  end
  assign attached = |att_match;

  always_comb begin
    cnt_d       = cnt_q;
    empty_vld_d = empty_vld_q;
    empty_d     = empty_q;
    chosen_d    = chosen_q;
    same_d      = same_q;
    status_d    = status_q;
    ptr_d       = ptr_q;
    if (cmd_i.load) begin
      cnt_d       = '0;
      empty_vld_d = 1'b0;
      chosen_d    = '0;
      same_d      = 1'b0;
      status_d    = 1'b0;
    end
    if (cmd_i.commit) begin
      status_d = !commit_ok;
      if (commit_ok && rd_valid && (rd_sensor != key_q)) begin
        ptr_d = (idx_slot == LastSlot) ? '0 : idx_slot + 1'b1;
      end
    end
    if (cmd_i.match) begin
      cnt_d = last ? '0 : cnt_q + 1'b1;
      if (hit) begin
        chosen_d = cnt_q;
        same_d   = (rec_fw_q[rd_addr] == fw_q) && (rec_cal_q[rd_addr] == cal_q);
      end else begin
        if (!rd_valid && !empty_vld_q) begin
          empty_vld_d = 1'b1;
          empty_d     = cnt_q;
        end
        if (last && empty_vld_q) chosen_d = empty_q;
        else if (last && !rd_valid) chosen_d = cnt_q;
      end
    end
    if (cmd_i.evict) begin
      cnt_d = last ? '0 : cnt_q + 1'b1;
      if (!attached)  chosen_d = evict_slot;
      else if (last)  chosen_d = ptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q   <= '0;
      att_present_q <= '0;
      ptr_q         <= '0;
      cnt_q         <= '0;
      empty_vld_q   <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      empty_vld_q <= empty_vld_d;
      if (cmd_i.attach && idx_ok) att_present_q[idx_slot] <= cvalid_q;
      if (cmd_i.commit && commit_ok) rec_valid_q[idx_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    empty_q  <= empty_d;
    chosen_q <= chosen_d;
    same_q   <= same_d;
    status_q <= status_d;
    if (cmd_i.load) begin
      func_q   <= func_i;
      cvalid_q <= candidate_valid_i;
      key_q    <= sensor_key_i;
      fw_q     <= firmware_key_i;
      cal_q    <= cal_version_i;
      idx_q    <= slot_index_i;
    end
    if (cmd_i.attach && idx_ok) att_sensor_q[idx_slot] <= key_q;
    if (cmd_i.commit && commit_ok) begin
      rec_sensor_q[idx_slot] <= key_q;
      rec_fw_q[idx_slot]     <= fw_q;
      rec_cal_q[idx_slot]    <= cal_q;
    end
  end

  always_comb begin
    stat_o           = '0;
    stat_o.func      = func_q;
    stat_o.cvalid    = cvalid_q;
    stat_o.match_end = hit || last;
    stat_o.go_evict  = last && !hit && !empty_vld_q && rd_valid;
    stat_o.evict_end = !attached || last;
  end

  assign chosen_slot_o = slot_to_out(chosen_q);
  assign unchanged_o   = same_q;
  assign status_o      = status_q;

endmodule

@@ rtl/sensor_slot_select_and_evict.sv @@
// Sensor slot table: select, commit and attached-list updates.
// Command channel: an item transfers at a rising edge with start_i high and
// busy_o low; func_i and the payload ports are sampled at that edge.
// Result channel: done_o is high for exactly one cycle per item, with
// chosen_slot_o, unchanged_o and status_o valid in that cycle. The receiver
// cannot stall; the result transfers at the edge ending the done_o cycle.
// Attach and commit pass through the dispatch state, their own state and the
// result state; unused codes and invalid select candidates go from dispatch
// straight to the result state. A select walks the slot table one slot per
// cycle through the single record read port until a match or the last slot,
// noting the first empty slot; with no match and no empty slot, an eviction
// walk follows, each step comparing one record against all attached entries
// in parallel. One item is in flight at a time; busy_o drops the cycle after
// done_o. Reset clears all record and attached valid marks and the eviction
// pointer; the block comes out of reset idle, ready to accept an item.
module sensor_slot_select_and_evict
  import ssse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          func_i,
  input  logic                candidate_valid_i,
  input  logic [KEY_W-1:0]    sensor_key_i,
  input  logic [KEY_W-1:0]    firmware_key_i,
  input  logic [CAL_W-1:0]    cal_version_i,
  input  logic [IDX_W-1:0]    slot_index_i,
  output logic                done_o,
  output logic [CHOSEN_W-1:0] chosen_slot_o,
  output logic                unchanged_o,
  output logic                status_o
);

  ssse_cmd_t  cmd;
  ssse_stat_t stat;

  ssse_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  ssse_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .func_i            (func_i),
    .candidate_valid_i (candidate_valid_i),
    .sensor_key_i      (sensor_key_i),
    .firmware_key_i    (firmware_key_i),
    .cal_version_i     (cal_version_i),
    .slot_index_i      (slot_index_i),
    .stat_o            (stat),
    .chosen_slot_o     (chosen_slot_o),
    .unchanged_o       (unchanged_o),
    .status_o          (status_o)
  );

endmodule
